[src/vsync_render_time_predictor_macros.svh]
// Assertion macros for the render-time predictor checker.
// Used by vrtp_checker.sv only; expects clk_i and rst_ni in the calling scope.
`ifndef VSYNC_RENDER_TIME_PREDICTOR_MACROS_SVH
`define VSYNC_RENDER_TIME_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VRTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define VRTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vrtp_pkg.sv]
// Shared types and constants for the vsync render-time predictor.
// No dependencies; imported by the top level and the divide-by-1000 pipeline.
`default_nettype none

package vrtp_pkg;

  // Event codes carried in the command field
  typedef enum logic [2:0] {
    CMD_VSYNC   = 3'd0,
    CMD_UPDATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_WAKE    = 3'd4
  } cmd_e;

  // Frame period after reset, microseconds
  localparam logic [31:0] DEFAULT_INTERVAL = 32'd16667;

  // Divide by 1000 of a 26-bit value: q = (v * DIV_RECIP) >> DIV_SHIFT, exact for v < 2^26
  localparam int unsigned DIV_SHIFT = 36;
  localparam logic [26:0] DIV_RECIP = 27'd68719477;

  // One radix-2^16 digit step of the long division by 1000
  typedef struct packed {
    logic [15:0] q;
    logic [9:0]  r;
  } div_step_t;

  // val = {remainder, next 16-bit chunk}, so val < 1000 * 2^16
  function automatic div_step_t div1000_step(input logic [25:0] val);
    logic [52:0] prod;
    logic [25:0] qx;
    div_step_t   res;
    prod  = {27'b0, val} * {26'b0, DIV_RECIP};
    res.q = prod[DIV_SHIFT +: 16];
    // q * 1000 = q*1024 - q*16 - q*8
    qx    = ({10'b0, res.q} << 10) - ({10'b0, res.q} << 4) - ({10'b0, res.q} << 3);
    res.r = 10'(val - qx);
    return res;
  endfunction

endpackage

`default_nettype wire

[src/vrtp_ifs.sv]
// Valid/ready channel interfaces for the render-time predictor events and results.
// No dependencies.
`default_nettype none

interface vrtp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] frame_number;
  logic [63:0] now_us;

  modport source (output valid, output command, output frame_number, output now_us,
                  input ready);
  modport sink   (input valid, input command, input frame_number, input now_us,
                  output ready);
endinterface

interface vrtp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] last_frame_delta_us;
  logic [31:0] last_render_ms;
  logic [31:0] next_render_ms;

  modport source (output valid, output last_frame_delta_us, output last_render_ms,
                  output next_render_ms, input ready);
  modport sink   (input valid, input last_frame_delta_us, input last_render_ms,
                  input next_render_ms, output ready);
endinterface

`default_nettype wire

[src/vrtp_div1000.sv]
// Four-stage pipeline: 64-bit value divided by 1000, low 32 quotient bits.
// Depends on vrtp_pkg (div1000_step). Stage loads come from the caller.
`default_nettype none

module vrtp_div1000
  import vrtp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [3:0]  en_i,
  input  wire logic [63:0] dividend_i,
  output logic      [31:0] quotient_o
);

  logic [9:0]  rem1_q, rem2_q, rem3_q;
  logic [47:0] rest1_q;
  logic [31:0] rest2_q;
  logic [15:0] rest3_q;
  logic [15:0] qhi3_q;
  logic [31:0] quot_q;

  div_step_t step1, step2, step3, step4;

  // One 16-bit digit per stage, remainder carried forward
  always_comb begin
    step1 = div1000_step({10'b0, dividend_i[63:48]});
    step2 = div1000_step({rem1_q, rest1_q[47:32]});
    step3 = div1000_step({rem2_q, rest2_q[31:16]});
    step4 = div1000_step({rem3_q, rest3_q});
  end

  // Upper quotient digits are dropped; only the low 32 bits are kept
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem1_q  <= step1.r;
      rest1_q <= dividend_i[47:0];
    end
    if (en_i[1]) begin
      rem2_q  <= step2.r;
      rest2_q <= rest1_q[31:0];
    end
    if (en_i[2]) begin
      rem3_q  <= step3.r;
      qhi3_q  <= step3.q;
      rest3_q <= rest2_q[15:0];
    end
    if (en_i[3]) begin
      quot_q  <= {qhi3_q, step4.q};
    end
  end

  assign quotient_o = quot_q;

endmodule

`default_nettype wire

[src/vsync_render_time_predictor.sv]
// Top level of the vsync render-time predictor.
// Depends on vrtp_pkg, vrtp_ifs (vrtp_in_if, vrtp_out_if) and vrtp_div1000.
`default_nettype none

// Takes one event per clock while in_i.ready is high. Vsync, suspend, resume and wake
// events update the internal state in the cycle they transfer and give no result. An
// update event taken while running gives one result after passing the stages: the input
// register, the history-average multiply, the frame-interval multiply, the 64-bit sum
// of last vsync time and wait, and four digit steps of the division by 1000. The
// pipeline closes bubbles, so events keep transferring while a result waits, until all
// eight stages hold updates. Configuration is written through cfg_we_i / cfg_wdata_i;
// the user must do so only while no update is in flight, the block does not enforce it.
module vsync_render_time_predictor
  import vrtp_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  vrtp_in_if.sink          in_i,
  vrtp_out_if.source       out_o
);

  localparam int unsigned NST       = 8;
  localparam int unsigned POS_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned AVG_SHIFT = 32 + $clog2(HISTORY_DEPTH);
  localparam int unsigned PROD_W    = AVG_SHIFT + 33;
  localparam logic [32:0] AVG_RECIP =
    33'(((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  // Configuration and event state
  logic [31:0]      interval_q;
  logic             running_q;
  logic             first_q;
  logic [63:0]      vsync_time_q;
  logic [63:0]      upd_time_q;
  logic [31:0]      vsync_frame_q;
  logic [31:0]      upd_frame_q;
  logic [31:0]      hist_q [HISTORY_DEPTH];
  logic [POS_W-1:0] pos_q;
  logic [31:0]      sum_q;
  logic [31:0]      extra_q;

  // Pipeline
  logic [NST-1:0]   v_q;
  logic [NST-1:0]   en;
  logic [31:0]      delta_q [NST];
  logic [31:0]      p1_sum_q;
  logic             p1_gt1_q, p2_gt1_q;
  logic [31:0]      p1_base_q, p2_base_q;
  logic [63:0]      p1_vsync_q, p2_vsync_q, p3_vsync_q, p4_vsync_q;
  logic [31:0]      p2_avg_q;
  logic [31:0]      p3_wait_q;
  logic [63:0]      p4_next_q;

  logic             accept;
  logic             upd_accept;
  logic [31:0]      frames_last;
  logic             frames_zero;
  logic [31:0]      extra_inc;
  logic [63:0]      delta_full;
  logic [31:0]      delta_sat;
  logic [PROD_W-1:0] avg_prod;
  logic [31:0]      frames_wait;
  logic [POS_W-1:0] pos_next;

  // Stage loads: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];
  assign accept     = in_i.valid && in_i.ready;
  assign upd_accept = accept && (in_i.command == CMD_UPDATE) && running_q;

  // Update bookkeeping from current state
  assign frames_last = vsync_frame_q - upd_frame_q;
  assign frames_zero = (frames_last == 32'd0);
  assign extra_inc   = extra_q + 32'd1;
  assign delta_full  = vsync_time_q - upd_time_q;
  assign delta_sat   = (|delta_full[63:32]) ? 32'hFFFF_FFFF : delta_full[31:0];
  assign pos_next    = (pos_q == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= DEFAULT_INTERVAL;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  // Event state update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b1;
      first_q       <= 1'b1;
      vsync_time_q  <= '0;
      upd_time_q    <= '0;
      vsync_frame_q <= '0;
      upd_frame_q   <= '0;
      pos_q         <= '0;
      sum_q         <= '0;
      extra_q       <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept) begin
      case (in_i.command)
        CMD_VSYNC: begin
          if (running_q) begin
            vsync_time_q  <= in_i.now_us;
            vsync_frame_q <= in_i.frame_number;
          end
        end
        CMD_UPDATE: begin
          if (running_q) begin
            if (!first_q) begin
              extra_q       <= frames_zero ? extra_inc : 32'd0;
              hist_q[pos_q] <= frames_last;
              sum_q         <= sum_q - hist_q[pos_q] + frames_last;
              pos_q         <= pos_next;
            end
            upd_frame_q <= vsync_frame_q;
            upd_time_q  <= vsync_time_q;
            first_q     <= 1'b0;
          end
        end
        CMD_SUSPEND: begin
          running_q     <= 1'b0;
          vsync_frame_q <= '0;
          upd_frame_q   <= '0;
          pos_q         <= '0;
          sum_q         <= '0;
          extra_q       <= '0;
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_q[i] <= '0;
          end
        end
        CMD_RESUME: begin
          vsync_time_q <= in_i.now_us;
          first_q      <= 1'b1;
          running_q    <= 1'b1;
        end
        CMD_WAKE: begin
          vsync_time_q <= in_i.now_us;
          upd_time_q   <= in_i.now_us;
          first_q      <= 1'b1;
          running_q    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= upd_accept;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Average of the history and the selected frame count
  assign avg_prod    = PROD_W'(p1_sum_q) * PROD_W'(AVG_RECIP);
  assign frames_wait = (p2_gt1_q && (p2_avg_q > 32'd1)) ? p2_avg_q : p2_base_q;

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_sum_q   <= sum_q;
      p1_gt1_q   <= !first_q && (frames_last > 32'd1);
      p1_base_q  <= (!first_q && frames_zero) ? extra_inc + 32'd1 : 32'd1;
      p1_vsync_q <= vsync_time_q;
      delta_q[0] <= delta_sat;
    end
    if (en[1]) begin
      p2_avg_q   <= avg_prod[AVG_SHIFT +: 32];
      p2_gt1_q   <= p1_gt1_q;
      p2_base_q  <= p1_base_q;
      p2_vsync_q <= p1_vsync_q;
    end
    if (en[2]) begin
      p3_wait_q  <= 32'(interval_q * frames_wait);
      p3_vsync_q <= p2_vsync_q;
    end
    if (en[3]) begin
      p4_next_q  <= p3_vsync_q + {32'b0, p3_wait_q};
      p4_vsync_q <= p3_vsync_q;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) delta_q[k] <= delta_q[k-1];
    end
  end

  // Millisecond conversions
  vrtp_div1000 u_div_last (
    .clk_i      (clk_i),
    .en_i       (en[7:4]),
    .dividend_i (p4_vsync_q),
    .quotient_o (out_o.last_render_ms)
  );

  vrtp_div1000 u_div_next (
    .clk_i      (clk_i),
    .en_i       (en[7:4]),
    .dividend_i (p4_next_q),
    .quotient_o (out_o.next_render_ms)
  );

  assign out_o.valid               = v_q[NST-1];
  assign out_o.last_frame_delta_us = delta_q[NST-1];

endmodule

`default_nettype wire

[src/vrtp_checker.sv]
// Port-level checks for vsync_render_time_predictor, attached by bind.
// Depends on vsync_render_time_predictor_macros.svh.
`default_nettype none
`include "vsync_render_time_predictor_macros.svh"

module vrtp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_delta_i,
  input wire logic [31:0] out_last_i,
  input wire logic [31:0] out_next_i
);

  logic        out_stall;
  logic [95:0] out_data;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_data  = {out_delta_i, out_last_i, out_next_i};

  // A stalled result stays offered and unchanged
  `VRTP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result dropped while stalled")
  `VRTP_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_data), "result changed while stalled")

  // Input only backs up when the whole pipeline is blocked at the output
  `VRTP_ASSERT_NOW(a_in_block, !in_ready_i, out_stall, "input stalled without output stall")
  `VRTP_ASSERT_NOW(a_in_free, !out_stall, in_ready_i, "input stalled while output moves")

endmodule

bind vsync_render_time_predictor vrtp_checker u_vrtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_delta_i (out_o.last_frame_delta_us),
  .out_last_i  (out_o.last_render_ms),
  .out_next_i  (out_o.next_render_ms)
);

`default_nettype wire
